FILE: rtl/rsd_pkg.sv
`default_nettype none
package rsd_pkg;

  localparam int ByteW  = 8;
  localparam int ValueW = 21;
  localparam int KindW  = 3;
  localparam int QueueDepthDef = 4;

  localparam logic [ByteW-1:0] MrkTxPre   = 8'h81;
  localparam logic [ByteW-1:0] MrkTxEnd   = 8'h82;
  localparam logic [ByteW-1:0] MrkStart   = 8'h83;
  localparam logic [ByteW-1:0] MrkBlkPre  = 8'h84;
  localparam logic [ByteW-1:0] MrkRuleEnd = 8'h85;

  localparam logic [ByteW-1:0] Lead2Mask = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Code = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Mask = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Code = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Code = 8'hF0;

  typedef enum logic [KindW-1:0] {
    KIND_HEAD     = 3'd0,
    KIND_BODY     = 3'd1,
    KIND_RULE_END = 3'd2,
    KIND_BLK_END  = 3'd3,
    KIND_TX_END   = 3'd4,
    KIND_TX_START = 3'd5,
    KIND_ERROR    = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    OP_SYM,
    OP_START,
    OP_BLK_END,
    OP_TX_END,
    OP_RULE_END
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ValueW-1:0] value;
  } cmd_t;

endpackage
`default_nettype wire

FILE: rtl/rsd_front.sv
`default_nettype none
module rsd_front (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    take,
  input  wire logic [rsd_pkg::ByteW-1:0] in_byte,
  output logic                         push,
  output rsd_pkg::cmd_t                push_cmd
);

  logic [rsd_pkg::ByteW-1:0]  prev_r, prev_nxt;
  logic [1:0]                 left_r, left_nxt;
  logic [rsd_pkg::ValueW-1:0] acc_r, acc_nxt;
  logic                       emit;

  always_comb begin
    prev_nxt = prev_r;
    left_nxt = left_r;
    acc_nxt  = acc_r;
    emit     = 1'b0;
    push_cmd.op    = rsd_pkg::OP_SYM;
    push_cmd.value = '0;
    if (left_r != 2'd0) begin
      acc_nxt  = {acc_r[rsd_pkg::ValueW-7:0], in_byte[5:0]};
      left_nxt = 2'(left_r - 2'd1);
      if (left_r == 2'd1) begin
        emit           = 1'b1;
        push_cmd.value = acc_nxt;
      end
    end else begin
      prev_nxt = in_byte;
      if (in_byte == rsd_pkg::MrkTxPre || in_byte == rsd_pkg::MrkBlkPre) begin
        emit = 1'b0;
      end else if (in_byte == rsd_pkg::MrkStart && prev_r == rsd_pkg::MrkTxPre) begin
        emit        = 1'b1;
        push_cmd.op = rsd_pkg::OP_START;
      end else if (in_byte == rsd_pkg::MrkStart && prev_r == rsd_pkg::MrkBlkPre) begin
        emit        = 1'b1;
        push_cmd.op = rsd_pkg::OP_BLK_END;
      end else if (in_byte == rsd_pkg::MrkTxEnd && prev_r == rsd_pkg::MrkBlkPre) begin
        emit        = 1'b1;
        push_cmd.op = rsd_pkg::OP_TX_END;
      end else if (in_byte == rsd_pkg::MrkRuleEnd) begin
        emit        = 1'b1;
        push_cmd.op = rsd_pkg::OP_RULE_END;
      end else if ((in_byte & rsd_pkg::Lead2Mask) == rsd_pkg::Lead2Code) begin
        acc_nxt  = rsd_pkg::ValueW'(in_byte[4:0]);
        left_nxt = 2'd1;
      end else if ((in_byte & rsd_pkg::Lead3Mask) == rsd_pkg::Lead3Code) begin
        acc_nxt  = rsd_pkg::ValueW'(in_byte[3:0]);
        left_nxt = 2'd2;
      end else if ((in_byte & rsd_pkg::Lead4Mask) == rsd_pkg::Lead4Code) begin
        acc_nxt  = rsd_pkg::ValueW'(in_byte[2:0]);
        left_nxt = 2'd3;
      end else begin
        acc_nxt        = rsd_pkg::ValueW'(in_byte);
        emit           = 1'b1;
        push_cmd.value = acc_nxt;
      end
    end
  end

  assign push = take && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      left_r <= '0;
      acc_r  <= '0;
    end else if (take) begin
      prev_r <= prev_nxt;
      left_r <= left_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/rsd_queue.sv
`default_nettype none
module rsd_queue #(
  parameter int Depth = rsd_pkg::QueueDepthDef
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  rsd_pkg::cmd_t      push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               q_valid,
  output rsd_pkg::cmd_t      q_cmd
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);

  rsd_pkg::cmd_t  mem_r [Depth];
  logic [AW-1:0]  wptr_r, rptr_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push, do_pop;

  assign full    = (cnt_r == CW'(Depth));
  assign q_valid = (cnt_r != '0);
  assign q_cmd   = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= (wptr_r == LastIdx) ? '0 : AW'(wptr_r + 1'b1);
      if (do_pop)  rptr_r <= (rptr_r == LastIdx) ? '0 : AW'(rptr_r + 1'b1);
      if (do_push && !do_pop)      cnt_r <= CW'(cnt_r + 1'b1);
      else if (do_pop && !do_push) cnt_r <= CW'(cnt_r - 1'b1);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/rsd_back.sv
`default_nettype none
module rsd_back (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     q_valid,
  input  rsd_pkg::cmd_t                 q_cmd,
  output logic                          pop,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [rsd_pkg::KindW-1:0]     out_kind,
  output logic [rsd_pkg::ValueW-1:0]    out_value
);

  logic                        valid_r;
  rsd_pkg::kind_t              kind_r, kind_nxt;
  logic [rsd_pkg::ValueW-1:0]  value_r, value_nxt;
  logic                        open_r, open_nxt;

  assign pop = q_valid && (!valid_r || out_ready);

  always_comb begin
    open_nxt  = open_r;
    kind_nxt  = rsd_pkg::KIND_ERROR;
    value_nxt = '0;
    case (q_cmd.op)
      rsd_pkg::OP_SYM: begin
        kind_nxt  = open_r ? rsd_pkg::KIND_BODY : rsd_pkg::KIND_HEAD;
        value_nxt = q_cmd.value;
        open_nxt  = 1'b1;
      end
      rsd_pkg::OP_START: begin
        kind_nxt = rsd_pkg::KIND_TX_START;
        open_nxt = 1'b0;
      end
      rsd_pkg::OP_BLK_END: begin
        kind_nxt = open_r ? rsd_pkg::KIND_BLK_END : rsd_pkg::KIND_ERROR;
        open_nxt = 1'b0;
      end
      rsd_pkg::OP_TX_END: begin
        kind_nxt = open_r ? rsd_pkg::KIND_TX_END : rsd_pkg::KIND_ERROR;
      end
      rsd_pkg::OP_RULE_END: begin
        kind_nxt = open_r ? rsd_pkg::KIND_RULE_END : rsd_pkg::KIND_ERROR;
        open_nxt = 1'b0;
      end
      default: begin
        kind_nxt = rsd_pkg::KIND_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      open_r  <= 1'b0;
    end else begin
      if (pop) begin
        valid_r <= 1'b1;
        open_r  <= open_nxt;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r  <= kind_nxt;
      value_r <= value_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_kind  = kind_r;
  assign out_value = value_r;

endmodule
`default_nettype wire

FILE: rtl/rule_stream_deframer_top.sv
// A completed result passes through a QueueDepth-entry command queue, which decouples
// the front decoder from the back rule tracker, and then the output register.
// Throughput: 1 byte per cycle while the queue is not full.
// Reset: synchronous, active-low rst_n clears decode state, queue and output
// register; in_ready is high in the first cycle after reset.
`default_nettype none
module rule_stream_deframer_top #(
  parameter int QueueDepth = rsd_pkg::QueueDepthDef
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [rsd_pkg::ByteW-1:0]  in_byte,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [rsd_pkg::KindW-1:0]       out_kind,
  output logic [rsd_pkg::ValueW-1:0]      out_value
);

  logic          take, push, full, pop, q_valid;
  rsd_pkg::cmd_t push_cmd, q_cmd;

  assign in_ready = !full;
  assign take     = in_valid && in_ready;

  rsd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .in_byte  (in_byte),
    .push     (push),
    .push_cmd (push_cmd)
  );

  rsd_queue #(.Depth(QueueDepth)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  rsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .out_value (out_value)
  );

endmodule
`default_nettype wire

FILE: rtl/rsd_checker.sv
`default_nettype none
module rsd_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic [rsd_pkg::ByteW-1:0]  in_byte,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [rsd_pkg::KindW-1:0]  out_kind,
  input wire logic [rsd_pkg::ValueW-1:0] out_value
);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("outputs not cleared by reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_value))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_byte))
    else $error("stalled input transfer changed");

  a_marker_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != rsd_pkg::KIND_HEAD && out_kind != rsd_pkg::KIND_BODY
      |-> out_value == '0)
    else $error("marker result with nonzero value");

  a_in_quiet_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(in_valid && in_ready) && !$past(in_valid && in_ready, 2)
      && !$past(out_valid) |-> !out_valid || $past(in_valid && in_ready, 3)
      || $past(!in_ready))
    else $error("result appeared with no byte transfer");

endmodule

bind rule_stream_deframer_top rsd_checker u_rsd_checker (.*);
`default_nettype wire
